// ----- hw/rtl/kcpt_pkg.sv -----
// shared types, key codes and constants for the keypad complementary pulse timer
`timescale 1ns / 1ps
`default_nettype none

package kcpt_pkg;

    // default counter width for timing registers
    localparam int DEF_COUNT_WIDTH = 20;

    // reset values of the timing settings
    localparam logic [31:0] ON_TICKS_RESET   = 32'd100;
    localparam logic [31:0] OFF_TICKS_RESET  = 32'd100;
    localparam logic [31:0] RUN_LENGTH_RESET = 32'd1000;

    // accepted range of a committed entry
    localparam logic [31:0] ENTRY_MIN = 32'd100;
    localparam logic [31:0] ENTRY_MAX = 32'd999900;

    // item kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_KEY  = 1'b1;

    // key codes
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_A         = 4'd10;
    localparam logic [3:0] KEY_B         = 4'd11;
    localparam logic [3:0] KEY_C         = 4'd12;
    localparam logic [3:0] KEY_D         = 4'd13;
    localparam logic [3:0] KEY_STAR      = 4'd14;
    localparam logic [3:0] KEY_HASH      = 4'd15;

    // edit targets
    localparam logic [1:0] EDIT_ON  = 2'd0;
    localparam logic [1:0] EDIT_OFF = 2'd1;
    localparam logic [1:0] EDIT_RUN = 2'd2;
    localparam logic [1:0] EDIT_BAD = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic [3:0] key_code;
    } kcpt_in_t;

    typedef struct packed {
        logic        pulse_a;
        logic        pulse_b;
        logic        running_led;
        logic [1:0]  edit_target;
        logic [31:0] entry_shown;
    } kcpt_out_t;

endpackage : kcpt_pkg

`default_nettype wire

// ----- hw/rtl/kcpt_engine.sv -----
// timer, phase and keypad entry state with next-state logic for one item
`timescale 1ns / 1ps
`default_nettype none

module kcpt_engine
    import kcpt_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire kcpt_in_t  item,
    output kcpt_out_t      result
);

    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    cnt_t        on_ticks_reg,    on_ticks_next;
    cnt_t        off_ticks_reg,   off_ticks_next;
    cnt_t        run_length_reg,  run_length_next;
    cnt_t        phase_count_reg, phase_count_next;
    cnt_t        remaining_reg,   remaining_next;
    logic        active_reg,      active_next;
    logic        phase_high_reg,  phase_high_next;
    logic [31:0] entry_reg,       entry_next;
    logic [1:0]  edit_mode_reg,   edit_mode_next;
    logic        lvl_a_reg,       lvl_a_next;
    logic        lvl_b_reg,       lvl_b_next;
    logic        lvl_led_reg,     lvl_led_next;

    cnt_t        phase_inc;
    logic [31:0] entry_times_ten;
    logic        entry_in_range;

    assign phase_inc       = phase_count_reg + cnt_t'(1);
    assign entry_times_ten = {entry_reg[28:0], 3'b000} + {entry_reg[30:0], 1'b0};
    assign entry_in_range  = (entry_reg >= ENTRY_MIN) && (entry_reg <= ENTRY_MAX);

    // next state for one item
    always_comb
    begin
        on_ticks_next    = on_ticks_reg;
        off_ticks_next   = off_ticks_reg;
        run_length_next  = run_length_reg;
        phase_count_next = phase_count_reg;
        remaining_next   = remaining_reg;
        active_next      = active_reg;
        phase_high_next  = phase_high_reg;
        entry_next       = entry_reg;
        edit_mode_next   = edit_mode_reg;
        lvl_a_next       = lvl_a_reg;
        lvl_b_next       = lvl_b_reg;
        lvl_led_next     = lvl_led_reg;

        if (item.req_type == REQ_TICK)
        begin
            if (active_reg)
            begin
                // phase advance and edge swap
                if (!phase_high_reg && (phase_inc >= on_ticks_reg))
                begin
                    lvl_a_next       = 1'b0;
                    lvl_b_next       = 1'b1;
                    phase_high_next  = 1'b1;
                    phase_count_next = '0;
                end
                else if (phase_high_reg && (phase_inc >= off_ticks_reg))
                begin
                    lvl_a_next       = 1'b1;
                    lvl_b_next       = 1'b0;
                    phase_high_next  = 1'b0;
                    phase_count_next = '0;
                end
                else
                begin
                    phase_count_next = phase_inc;
                end

                // run length countdown
                if (remaining_reg != '0)
                begin
                    remaining_next = remaining_reg - cnt_t'(1);
                    if (remaining_reg == cnt_t'(1))
                    begin
                        active_next  = 1'b0;
                        lvl_a_next   = 1'b0;
                        lvl_b_next   = 1'b0;
                        lvl_led_next = 1'b0;
                    end
                end
            end
        end
        else if (item.key_code <= KEY_DIGIT_MAX)
        begin
            entry_next = entry_times_ten + {28'd0, item.key_code};
        end
        else
        begin
            case (item.key_code)
                KEY_A:
                begin
                    if (!active_reg)
                    begin
                        active_next    = 1'b1;
                        remaining_next = run_length_reg;
                        lvl_led_next   = 1'b1;
                    end
                    else
                    begin
                        active_next  = 1'b0;
                        lvl_a_next   = 1'b0;
                        lvl_b_next   = 1'b0;
                        lvl_led_next = 1'b0;
                    end
                end
                KEY_B:
                begin
                    edit_mode_next = EDIT_ON;
                    entry_next     = 32'(on_ticks_reg);
                end
                KEY_C:
                begin
                    edit_mode_next = EDIT_OFF;
                    entry_next     = 32'(off_ticks_reg);
                end
                KEY_D:
                begin
                    edit_mode_next = EDIT_RUN;
                    entry_next     = 32'(run_length_reg);
                end
                KEY_HASH:
                begin
                    if (entry_in_range)
                    begin
                        case (edit_mode_reg)
                            EDIT_ON:  on_ticks_next   = cnt_t'(entry_reg);
                            EDIT_OFF: off_ticks_next  = cnt_t'(entry_reg);
                            default:  run_length_next = cnt_t'(entry_reg);
                        endcase
                    end
                    entry_next = '0;
                end
                default:
                begin
                    // star key leaves everything as it is
                end
            endcase
        end
    end

    // result item follows the updated state
    always_comb
    begin
        result.pulse_a     = lvl_a_next;
        result.pulse_b     = lvl_b_next;
        result.running_led = lvl_led_next;
        result.edit_target = edit_mode_next;
        result.entry_shown = entry_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_ticks_reg    <= cnt_t'(ON_TICKS_RESET);
            off_ticks_reg   <= cnt_t'(OFF_TICKS_RESET);
            run_length_reg  <= cnt_t'(RUN_LENGTH_RESET);
            phase_count_reg <= '0;
            remaining_reg   <= '0;
            active_reg      <= 1'b0;
            phase_high_reg  <= 1'b0;
            entry_reg       <= '0;
            edit_mode_reg   <= EDIT_ON;
            lvl_a_reg       <= 1'b0;
            lvl_b_reg       <= 1'b0;
            lvl_led_reg     <= 1'b0;
        end
        else if (step)
        begin
            on_ticks_reg    <= on_ticks_next;
            off_ticks_reg   <= off_ticks_next;
            run_length_reg  <= run_length_next;
            phase_count_reg <= phase_count_next;
            remaining_reg   <= remaining_next;
            active_reg      <= active_next;
            phase_high_reg  <= phase_high_next;
            entry_reg       <= entry_next;
            edit_mode_reg   <= edit_mode_next;
            lvl_a_reg       <= lvl_a_next;
            lvl_b_reg       <= lvl_b_next;
            lvl_led_reg     <= lvl_led_next;
        end
    end

    // complementary outputs never overlap
    assert property (@(posedge clk) disable iff (!rst_n) !(lvl_a_reg && lvl_b_reg))
        else $error("pulse outputs high together");

    // led tracks the run state
    assert property (@(posedge clk) disable iff (!rst_n) lvl_led_reg == active_reg)
        else $error("led differs from run state");

    // pulses only drive while running
    assert property (@(posedge clk) disable iff (!rst_n)
        (lvl_a_reg || lvl_b_reg) |-> active_reg)
        else $error("pulse output high while stopped");

    // edit target stays among the three settings
    assert property (@(posedge clk) disable iff (!rst_n) edit_mode_reg != EDIT_BAD)
        else $error("edit target out of range");

endmodule : kcpt_engine

`default_nettype wire

// ----- hw/rtl/keypad_complementary_pulse_timer.sv -----
// top level of the keypad complementary pulse timer with registered result item
`timescale 1ns / 1ps
`default_nettype none

// Keypad complementary pulse timer. Each input item is a timer tick or a key
// press and yields exactly one result item with the pulse levels, the run led,
// the edit target and the entry value after that item. An item is handled in
// a single pass of logic at acceptance and its result appears in the output
// register on the next cycle, so one item is taken every cycle.
// A new item is accepted whenever the output register is empty or is being
// taken in the same cycle; the only thing that holds the input back is a
// stalled consumer. COUNT_WIDTH (20 to 32) sets the width of the on time, off
// time, duration and phase counters.

module keypad_complementary_pulse_timer
    import kcpt_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire kcpt_in_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output kcpt_out_t      out_item
);

    logic      step;
    kcpt_out_t result;
    logic      out_valid_reg, out_valid_next;
    kcpt_out_t out_item_reg;

    // accept when the result slot is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    kcpt_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item),
        .result (result)
    );

    // output valid tracking
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule : keypad_complementary_pulse_timer

`default_nettype wire

// ----- test/keypad_complementary_pulse_timer_tb.sv -----
// self-checking testbench for the keypad complementary pulse timer
`timescale 1ns / 1ps

module keypad_complementary_pulse_timer_tb;

    import kcpt_pkg::*;

    localparam int CW          = DEF_COUNT_WIDTH;
    localparam int ITEMS_TOTAL = 1950;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_ROWS    = 23;

    // one row of the directed table: item and, where obvious, the typed result
    typedef struct {
        kcpt_in_t  item;
        bit        pinned;
        kcpt_out_t want;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    kcpt_in_t  in_item;
    logic      out_valid;
    logic      out_ready;
    kcpt_out_t out_item;

    // typed expectation travels with the item it belongs to
    logic      pin_flag;
    kcpt_out_t pin_val;

    kcpt_out_t   levels_due[$];
    dir_row_t    dir_table[DIR_ROWS];
    int          errors;
    int          sent;
    int          burst_left;
    int          cycle_count;
    logic [15:0] rcv_cyc;

    // timer state as the predictor sees it
    logic [CW-1:0] m_on;
    logic [CW-1:0] m_off;
    logic [CW-1:0] m_run;
    logic [CW-1:0] m_phase;
    logic [CW-1:0] m_left;
    logic          m_running;
    logic          m_high;
    logic [31:0]   m_entry;
    logic [1:0]    m_target;
    logic          m_a;
    logic          m_b;
    logic          m_led;

    keypad_complementary_pulse_timer #(
        .COUNT_WIDTH (CW)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic timer_reset_state();
        m_on      = ON_TICKS_RESET[CW-1:0];
        m_off     = OFF_TICKS_RESET[CW-1:0];
        m_run     = RUN_LENGTH_RESET[CW-1:0];
        m_phase   = '0;
        m_left    = '0;
        m_running = 1'b0;
        m_high    = 1'b0;
        m_entry   = '0;
        m_target  = EDIT_ON;
        m_a       = 1'b0;
        m_b       = 1'b0;
        m_led     = 1'b0;
    endtask

    // advance the timer state by one item and form its result
    task automatic timer_advance(input kcpt_in_t it, output kcpt_out_t res);
        logic [CW-1:0] v;
        if (it.req_type == REQ_TICK)
        begin
            if (m_running)
            begin
                m_phase = m_phase + CW'(1);
                if (!m_high && m_phase >= m_on)
                begin
                    m_a     = 1'b0;
                    m_b     = 1'b1;
                    m_high  = 1'b1;
                    m_phase = '0;
                end
                else if (m_high && m_phase >= m_off)
                begin
                    m_a     = 1'b1;
                    m_b     = 1'b0;
                    m_high  = 1'b0;
                    m_phase = '0;
                end
                if (m_left != '0)
                begin
                    m_left = m_left - CW'(1);
                    if (m_left == '0)
                    begin
                        m_running = 1'b0;
                        m_a       = 1'b0;
                        m_b       = 1'b0;
                        m_led     = 1'b0;
                    end
                end
            end
        end
        else if (it.key_code <= KEY_DIGIT_MAX)
        begin
            m_entry = m_entry * 32'd10 + 32'(it.key_code);
        end
        else
        begin
            case (it.key_code)
                KEY_A:
                begin
                    if (!m_running)
                    begin
                        m_running = 1'b1;
                        m_left    = m_run;
                        m_led     = 1'b1;
                    end
                    else
                    begin
                        m_running = 1'b0;
                        m_a       = 1'b0;
                        m_b       = 1'b0;
                        m_led     = 1'b0;
                    end
                end
                KEY_B:
                begin
                    m_target = EDIT_ON;
                    m_entry  = 32'(m_on);
                end
                KEY_C:
                begin
                    m_target = EDIT_OFF;
                    m_entry  = 32'(m_off);
                end
                KEY_D:
                begin
                    m_target = EDIT_RUN;
                    m_entry  = 32'(m_run);
                end
                KEY_HASH:
                begin
                    if (m_entry >= ENTRY_MIN && m_entry <= ENTRY_MAX)
                    begin
                        v = m_entry[CW-1:0];
                        case (m_target)
                            EDIT_ON:  m_on  = v;
                            EDIT_OFF: m_off = v;
                            default:  m_run = v;
                        endcase
                    end
                    m_entry = '0;
                end
                default:
                begin
                    // star key does nothing
                end
            endcase
        end
        res.pulse_a     = m_a;
        res.pulse_b     = m_b;
        res.running_led = m_led;
        res.edit_target = m_target;
        res.entry_shown = m_entry;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // predict on every accepted item, check every accepted result
    always @(posedge clk)
    begin : watch_ports
        kcpt_out_t pred;
        kcpt_out_t head;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                timer_advance(in_item, pred);
                if (pin_flag)
                    levels_due.push_back(pin_val);
                else
                    levels_due.push_back(pred);
            end
            if (out_valid && out_ready)
            begin
                if (levels_due.size() == 0)
                begin
                    $display("%0t: result with none expected, expected nothing, actual %p",
                             $time, out_item);
                    errors++;
                end
                else
                begin
                    head = levels_due.pop_front();
                    check_field("pulse_a", 32'(head.pulse_a), 32'(out_item.pulse_a));
                    check_field("pulse_b", 32'(head.pulse_b), 32'(out_item.pulse_b));
                    check_field("running_led", 32'(head.running_led),
                                32'(out_item.running_led));
                    check_field("edit_target", 32'(head.edit_target),
                                32'(out_item.edit_target));
                    check_field("entry_shown", head.entry_shown, out_item.entry_shown);
                end
            end
        end
    end

    // consumer stalls, changing its pattern with bits 10:9 of its cycle counter
    always @(posedge clk)
    begin
        rcv_cyc <= rcv_cyc + 16'd1;
        case (rcv_cyc[10:9])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    out_ready <= (rcv_cyc[2:0] != 3'd5) && (rcv_cyc[2:0] != 3'd6);
            default: out_ready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    function automatic kcpt_in_t key_item(input logic [3:0] k);
        kcpt_in_t it;
        it.req_type = REQ_KEY;
        it.key_code = k;
        return it;
    endfunction

    function automatic kcpt_in_t tick_item();
        kcpt_in_t it;
        it.req_type = REQ_TICK;
        it.key_code = 4'($urandom_range(0, 15));
        return it;
    endfunction

    function automatic dir_row_t drow(input logic req, input logic [3:0] k, input bit pin,
                                      input logic led, input logic [1:0] tgt,
                                      input logic [31:0] ent);
        dir_row_t r;
        r.item.req_type       = req;
        r.item.key_code       = k;
        r.pinned              = pin;
        r.want.pulse_a        = 1'b0;
        r.want.pulse_b        = 1'b0;
        r.want.running_led    = led;
        r.want.edit_target    = tgt;
        r.want.entry_shown    = ent;
        return r;
    endfunction

    // send one item, with a random gap between bursts
    task automatic send_item(input kcpt_in_t it, input bit pin, input kcpt_out_t pv);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 25);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        pin_flag <= pin;
        pin_val  <= pv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_plain(input kcpt_in_t it);
        send_item(it, 1'b0, '0);
    endtask

    // hold off until every expected result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (levels_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_number(input int unsigned v);
        logic [3:0] digs[$];
        do
        begin
            digs.push_front(4'(v % 10));
            v = v / 10;
        end
        while (v != 0);
        foreach (digs[i])
            send_plain(key_item(digs[i]));
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send_plain(tick_item());
    endtask

    // select a target, clear the entry, type a value and commit it
    task automatic program_setting();
        logic [3:0]  sel;
        int unsigned v;
        int          pick;
        case ($urandom_range(0, 2))
            0:       sel = KEY_B;
            1:       sel = KEY_C;
            default: sel = KEY_D;
        endcase
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            case ($urandom_range(0, 3))
                0:       v = 99;
                1:       v = 100;
                2:       v = 999900;
                default: v = 999901;
            endcase
        end
        else if (pick == 1)
            v = $urandom;
        else if (sel == KEY_D)
            v = $urandom_range(100, 700);
        else
            v = $urandom_range(100, 300);
        send_plain(key_item(sel));
        send_plain(key_item(KEY_HASH));
        send_number(v);
        // extra digits push the entry past 32 bits
        if (pick == 1)
            repeat ($urandom_range(0, 2))
                send_plain(key_item(4'($urandom_range(0, 9))));
        send_plain(key_item(KEY_HASH));
    endtask

    // half-typed entries and stray keys
    task automatic send_broken();
        case ($urandom_range(0, 2))
            0:
            begin
                send_plain(key_item(4'($urandom_range(KEY_B, KEY_D))));
                repeat ($urandom_range(1, 4))
                    send_plain(key_item(4'($urandom_range(0, 9))));
            end
            1:
            begin
                send_plain(key_item(4'($urandom_range(0, 9))));
                send_plain(key_item(KEY_STAR));
                send_plain(key_item(KEY_HASH));
            end
            default:
                repeat ($urandom_range(8, 12))
                    send_plain(key_item(4'($urandom_range(0, 9))));
        endcase
    endtask

    task automatic send_noise();
        kcpt_in_t it;
        repeat ($urandom_range(1, 6))
        begin
            it.req_type = 1'($urandom_range(0, 1));
            it.key_code = 4'($urandom_range(0, 15));
            send_plain(it);
        end
    endtask

    // stimulus
    initial
    begin
        int  kind;
        bit  paused;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        pin_flag    = 1'b0;
        pin_val     = '0;
        out_ready   = 1'b0;
        rcv_cyc     = '0;
        errors      = 0;
        sent        = 0;
        burst_left  = 0;
        cycle_count = 0;
        paused      = 1'b0;
        timer_reset_state();

        // reset values, edit keys, commit edges, entry wrap, star, start and stop
        dir_table[0]  = drow(REQ_TICK, KEY_A,    1, 1'b0, EDIT_ON,  32'd0);
        dir_table[1]  = drow(REQ_KEY,  KEY_B,    1, 1'b0, EDIT_ON,  32'd100);
        dir_table[2]  = drow(REQ_KEY,  KEY_C,    1, 1'b0, EDIT_OFF, 32'd100);
        dir_table[3]  = drow(REQ_KEY,  KEY_D,    1, 1'b0, EDIT_RUN, 32'd1000);
        dir_table[4]  = drow(REQ_KEY,  4'd9,     0, 1'b0, EDIT_RUN, 32'd0);
        dir_table[5]  = drow(REQ_KEY,  KEY_HASH, 1, 1'b0, EDIT_RUN, 32'd0);
        dir_table[6]  = drow(REQ_KEY,  4'd9,     0, 1'b0, EDIT_RUN, 32'd0);
        dir_table[7]  = drow(REQ_KEY,  4'd9,     0, 1'b0, EDIT_RUN, 32'd0);
        dir_table[8]  = drow(REQ_KEY,  4'd9,     0, 1'b0, EDIT_RUN, 32'd0);
        dir_table[9]  = drow(REQ_KEY,  4'd9,     0, 1'b0, EDIT_RUN, 32'd0);
        dir_table[10] = drow(REQ_KEY,  4'd0,     0, 1'b0, EDIT_RUN, 32'd0);
        dir_table[11] = drow(REQ_KEY,  4'd0,     0, 1'b0, EDIT_RUN, 32'd0);
        dir_table[12] = drow(REQ_KEY,  KEY_HASH, 1, 1'b0, EDIT_RUN, 32'd0);
        dir_table[13] = drow(REQ_KEY,  KEY_D,    1, 1'b0, EDIT_RUN, 32'd999900);
        dir_table[14] = drow(REQ_KEY,  4'd9,     0, 1'b0, EDIT_RUN, 32'd0);
        dir_table[15] = drow(REQ_KEY,  4'd9,     0, 1'b0, EDIT_RUN, 32'd0);
        dir_table[16] = drow(REQ_KEY,  4'd9,     0, 1'b0, EDIT_RUN, 32'd0);
        dir_table[17] = drow(REQ_KEY,  4'd9,     0, 1'b0, EDIT_RUN, 32'd0);
        dir_table[18] = drow(REQ_KEY,  KEY_HASH, 1, 1'b0, EDIT_RUN, 32'd0);
        dir_table[19] = drow(REQ_KEY,  KEY_STAR, 1, 1'b0, EDIT_RUN, 32'd0);
        dir_table[20] = drow(REQ_KEY,  KEY_A,    1, 1'b1, EDIT_RUN, 32'd0);
        dir_table[21] = drow(REQ_TICK, KEY_HASH, 1, 1'b1, EDIT_RUN, 32'd0);
        dir_table[22] = drow(REQ_KEY,  KEY_A,    1, 1'b0, EDIT_RUN, 32'd0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (dir_table[i])
            send_item(dir_table[i].item, dir_table[i].pinned, dir_table[i].want);

        // random part, mostly well-formed programming and timed runs
        while (sent < ITEMS_TOTAL)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 7)
                program_setting();
            else if (kind < 12)
            begin
                send_plain(key_item(KEY_A));
                send_ticks($urandom_range(20, 300));
            end
            else if (kind < 14)
                send_ticks($urandom_range(1, 60));
            else if (kind < 17)
                send_noise();
            else if (kind < 19)
                send_broken();
            else
                wait_drained();
            if (!paused && sent > ITEMS_TOTAL / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end

        // let the last results come back
        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
